// File: sv/pgf_pkg.sv
// Shared types and constants for the process grid factorizer.
// No dependencies; imported by every module of the block.
package pgf_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned FIELD_BITS         = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LP_CHECK,
      ST_LP_DIV,
      ST_LP_WAIT,
      ST_RATIO_DIV,
      ST_RATIO_WAIT,
      ST_REST_DIV,
      ST_REST_WAIT,
      ST_DOUBLE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

endpackage

// File: sv/pgf_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on pgf_pkg.
module pgf_divider #(
   parameter int unsigned WIDTH = pgf_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   import pgf_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [WIDTH:0]      shifted;
   logic [WIDTH:0]      diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/pgf_sort3.sv
// Three compare-swap stages that order the block counts largest first.
// Depends on pgf_pkg.
module pgf_sort3 #(
   parameter int unsigned WIDTH = pgf_pkg::COUNT_BITS_DEFAULT
) (
   input  logic [WIDTH-1:0] in_x,
   input  logic [WIDTH-1:0] in_y,
   input  logic [WIDTH-1:0] in_z,
   output logic [WIDTH-1:0] out_x,
   output logic [WIDTH-1:0] out_y,
   output logic [WIDTH-1:0] out_z
);
   import pgf_pkg::*;

   logic [WIDTH-1:0] y1, z1, x2, y2;

   always_comb begin
      // swap y and z
      y1 = (in_z > in_y) ? in_z : in_y;
      z1 = (in_z > in_y) ? in_y : in_z;
      // swap x and y
      x2 = (y1 > in_x) ? y1 : in_x;
      y2 = (y1 > in_x) ? in_x : y1;
      // swap y and z again
      out_x = x2;
      out_y = (z1 > y2) ? z1 : y2;
      out_z = (z1 > y2) ? y2 : z1;
   end

endmodule

// File: sv/process_grid_factorizer.sv
// Process grid factorizer: splits a process count into x, y and z block counts whose
// product is the count, returned largest first. One request is worked at a time; the
// block stalls its input from acceptance until the result is loaded into the output
// register, and the next request may be taken while that result waits. Run time is set by
// the trial division loop on the shared one-bit-per-cycle divider: trial divisors run up
// to the square root of the remaining cofactor, each division that strips a factor is
// followed by another with the same divisor, and a second search runs on the cofactor in
// three dimensions. A count of zero is handled as one.
// Depends on pgf_pkg, pgf_divider, pgf_sort3.
module process_grid_factorizer #(
   parameter int unsigned COUNT_BITS = pgf_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pgf_pkg::FIELD_BITS-1:0]  req_process_count,
   input  logic                            req_two_dimensional,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pgf_pkg::FIELD_BITS-1:0]  rsp_blocks_x,
   output logic [pgf_pkg::FIELD_BITS-1:0]  rsp_blocks_y,
   output logic [pgf_pkg::FIELD_BITS-1:0]  rsp_blocks_z
);
   import pgf_pkg::*;

   localparam int unsigned D_BITS  = (COUNT_BITS + 1) / 2 + 1;
   localparam int unsigned SQ_BITS = 2 * D_BITS;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  flat_ff, flat_in;
   logic [COUNT_BITS-1:0] lp_rest_ff, lp_rest_in;
   logic [COUNT_BITS-1:0] lp_best_ff, lp_best_in;
   logic [D_BITS-1:0]     d_ff, d_in;
   logic                  second_ff, second_in;
   logic [COUNT_BITS-1:0] g_ff, g_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic [COUNT_BITS-1:0] p_ff, p_in;
   logic [COUNT_BITS-1:0] bx_ff, bx_in;
   logic [COUNT_BITS-1:0] by_ff, by_in;
   logic [COUNT_BITS-1:0] bz_ff, bz_in;
   axis_type              axis_ff, axis_in;
   logic                  three_ff, three_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COUNT_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [COUNT_BITS-1:0] rsp_z_ff, rsp_z_in;

   logic                  accept;
   logic                  slot_free;
   logic [COUNT_BITS-1:0] req_count;
   logic [SQ_BITS-1:0]    d_sq;
   logic                  sq_over;
   logic [COUNT_BITS-1:0] lp_res;
   logic                  lp_is_two;
   logic                  p_short;

   logic                  div_start;
   logic [COUNT_BITS-1:0] div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic                  div_busy;
   logic                  div_done;
   logic [COUNT_BITS-1:0] div_quo;
   logic [COUNT_BITS-1:0] div_rem;

   logic [COUNT_BITS-1:0] sort_x, sort_y, sort_z;

   pgf_divider #(.WIDTH(COUNT_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pgf_sort3 #(.WIDTH(COUNT_BITS)) u_sort3 (
      .in_x  (bx_ff),
      .in_y  (by_ff),
      .in_z  (bz_ff),
      .out_x (sort_x),
      .out_y (sort_y),
      .out_z (sort_z)
   );

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_count = COUNT_BITS'(req_process_count);
   assign d_sq      = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);
   assign sq_over   = d_sq > SQ_BITS'(lp_rest_ff);
   // leftover cofactor above one is itself the greatest prime
   assign lp_res    = (lp_rest_ff > COUNT_BITS'(1)) ? lp_rest_ff : lp_best_ff;
   assign lp_is_two = lp_res == COUNT_BITS'(2);
   assign p_short   = p_ff < target_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LP_CHECK;
         end
         ST_LP_CHECK: begin
            if (!sq_over) begin
               state_in = ST_LP_DIV;
            end else if (second_ff) begin
               state_in = lp_is_two ? ST_DOUBLE : ST_REST_DIV;
            end else if (!lp_is_two) begin
               state_in = ST_RATIO_DIV;
            end else begin
               state_in = flat_ff ? ST_FINISH : ST_DOUBLE;
            end
         end
         ST_LP_DIV: begin
            state_in = ST_LP_WAIT;
         end
         ST_LP_WAIT: begin
            if (div_done) state_in = (div_rem == '0) ? ST_LP_DIV : ST_LP_CHECK;
         end
         ST_RATIO_DIV: begin
            state_in = ST_RATIO_WAIT;
         end
         ST_RATIO_WAIT: begin
            if (div_done) state_in = flat_ff ? ST_FINISH : ST_LP_CHECK;
         end
         ST_REST_DIV: begin
            state_in = ST_REST_WAIT;
         end
         ST_REST_WAIT: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_DOUBLE: begin
            if (!p_short) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall    = state_ff != ST_IDLE;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         ST_LP_DIV: begin
            div_start    = 1'b1;
            div_dividend = lp_rest_ff;
            div_divisor  = COUNT_BITS'(d_ff);
         end
         ST_RATIO_DIV: begin
            div_start    = 1'b1;
            div_dividend = count_ff;
            div_divisor  = g_ff;
         end
         ST_REST_DIV: begin
            div_start    = 1'b1;
            div_dividend = target_ff;
            div_divisor  = by_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      count_in     = count_ff;
      flat_in      = flat_ff;
      lp_rest_in   = lp_rest_ff;
      lp_best_in   = lp_best_ff;
      d_in         = d_ff;
      second_in    = second_ff;
      g_in         = g_ff;
      target_in    = target_ff;
      p_in         = p_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      bz_in        = bz_ff;
      axis_in      = axis_ff;
      three_in     = three_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in   = (req_count == '0) ? COUNT_BITS'(1) : req_count;
               lp_rest_in = (req_count == '0) ? COUNT_BITS'(1) : req_count;
               flat_in    = req_two_dimensional;
               lp_best_in = COUNT_BITS'(1);
               d_in       = D_BITS'(2);
               second_in  = 1'b0;
            end
         end
         ST_LP_CHECK: begin
            if (sq_over) begin
               if (!second_ff) begin
                  g_in = lp_res;
                  if (lp_is_two) begin
                     if (flat_ff) begin
                        bx_in = COUNT_BITS'(2);
                        by_in = count_ff >> 1;
                        bz_in = COUNT_BITS'(1);
                     end else begin
                        bx_in     = COUNT_BITS'(1);
                        by_in     = COUNT_BITS'(1);
                        bz_in     = COUNT_BITS'(1);
                        p_in      = COUNT_BITS'(1);
                        target_in = count_ff;
                        axis_in   = AXIS_X;
                        three_in  = 1'b1;
                     end
                  end
               end else if (!lp_is_two) begin
                  by_in = lp_res;
               end else begin
                  // cofactor is a power of two: double y and z in turn
                  by_in    = COUNT_BITS'(1);
                  bz_in    = COUNT_BITS'(1);
                  p_in     = COUNT_BITS'(1);
                  axis_in  = AXIS_Y;
                  three_in = 1'b0;
               end
            end
         end
         ST_LP_WAIT: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  lp_best_in = COUNT_BITS'(d_ff);
                  lp_rest_in = div_quo;
               end else begin
                  d_in = d_ff + D_BITS'(1);
               end
            end
         end
         ST_RATIO_WAIT: begin
            if (div_done) begin
               bx_in     = g_ff;
               target_in = div_quo;
               if (flat_ff) begin
                  by_in = div_quo;
                  bz_in = COUNT_BITS'(1);
               end else begin
                  lp_rest_in = div_quo;
                  lp_best_in = COUNT_BITS'(1);
                  d_in       = D_BITS'(2);
                  second_in  = 1'b1;
               end
            end
         end
         ST_REST_WAIT: begin
            if (div_done) bz_in = div_quo;
         end
         ST_DOUBLE: begin
            if (p_short) begin
               p_in = p_ff << 1;
               unique case (axis_ff)
                  AXIS_X: begin
                     bx_in   = bx_ff << 1;
                     axis_in = AXIS_Y;
                  end
                  AXIS_Y: begin
                     by_in   = by_ff << 1;
                     axis_in = AXIS_Z;
                  end
                  AXIS_Z: begin
                     bz_in   = bz_ff << 1;
                     axis_in = three_ff ? AXIS_X : AXIS_Y;
                  end
                  default: begin
                     axis_in = AXIS_X;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = sort_x;
               rsp_y_in     = sort_y;
               rsp_z_in     = sort_z;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff   <= count_in;
      flat_ff    <= flat_in;
      lp_rest_ff <= lp_rest_in;
      lp_best_ff <= lp_best_in;
      d_ff       <= d_in;
      second_ff  <= second_in;
      g_ff       <= g_in;
      target_ff  <= target_in;
      p_ff       <= p_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      bz_ff      <= bz_in;
      axis_ff    <= axis_in;
      three_ff   <= three_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_blocks_x = FIELD_BITS'(rsp_x_ff);
   assign rsp_blocks_y = FIELD_BITS'(rsp_y_ff);
   assign rsp_blocks_z = FIELD_BITS'(rsp_z_ff);

   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LP_CHECK)
      else $error("accepted request did not start the prime search");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_double_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DOUBLE |-> p_ff <= target_ff)
      else $error("doubling product overran its target");

   a_rsp_sorted: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_x_ff >= rsp_y_ff) && (rsp_y_ff >= rsp_z_ff))
      else $error("block counts not in descending order");

endmodule
